// ===== sv/slsf_pkg.sv =====
// Shared types, constants and helper functions for the sound level scale/format block.
// No dependencies; used by every other file through scoped names.
package slsf_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MAX_VALUE       = 2'd0;
    localparam logic [1:0] REG_LATCH_HOLD      = 2'd1;
    localparam logic [1:0] REG_LINK_CONNECTED  = 2'd2;
    localparam logic [1:0] REG_TRANSMIT_ENABLE = 2'd3;

    localparam logic [9:0]  MAX_VALUE_RESET = 10'd130;
    localparam logic [13:0] LEVEL_MAX       = 14'd9999;

    // level = (2*s*m*10)/1534 = (2*s*m*5)/767; floor(2^32/767) as reciprocal
    localparam logic [22:0] RECIP_767  = 23'd5599696;
    localparam logic [23:0] DIVISOR    = 24'd767;
    localparam logic [23:0] SAT_THRESH = 24'd7670000;  // 10000 * 767

    // bar step 1534/16 = 95; floor(d/95) = (d*690) >> 16 for d < 1425
    localparam logic [10:0] BAR_FULL_AT = 11'd1425;
    localparam logic [10:0] BAR_RECIP   = 11'd690;
    localparam logic [4:0]  BAR_CELLS   = 5'd16;

    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_DOT   = 8'd46;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef struct packed {
        logic [9:0] max_value;
        logic       latch;
        logic       frame_en;
    } cfg_t;

    typedef struct packed {
        logic [13:0] level;
        logic [4:0]  bars;
        logic        held;
        logic        frame_en;
        logic [3:0]  th;
        logic [3:0]  hu;
        logic [3:0]  te;
        logic [3:0]  un;
    } entry_t;

    typedef enum logic [6:0] {
        ST_NL  = 7'b0000001,
        ST_TH  = 7'b0000010,
        ST_HU  = 7'b0000100,
        ST_TE  = 7'b0001000,
        ST_DOT = 7'b0010000,
        ST_UN  = 7'b0100000,
        ST_TAB = 7'b1000000
    } frame_state_t;

    function automatic logic [4:0] bar_count(input logic [10:0] doubled);
        logic [20:0] prod;
        logic [4:0]  n;
        prod = 21'(doubled) * 21'(BAR_RECIP);
        if (doubled == 11'd0)
            n = 5'd0;
        else if (doubled >= BAR_FULL_AT)
            n = BAR_CELLS;
        else
            n = prod[20:16] + 5'd1;
        return n;
    endfunction

    // Decimal digit by parallel compares against multiples of the unit
    function automatic logic [3:0] digit_of(input logic [13:0] value, input logic [13:0] unit);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (value >= 14'(k) * unit)
                d = 4'(k);
        end
        return d;
    endfunction

endpackage

// ===== sv/sound_level_scale_format.sv =====
// Sound level scaling and ASCII level frame, top level.
// Depends on slsf_pkg, slsf_front, slsf_queue and slsf_back.
//
// Each accepted 10-bit sample passes a seven-stage front pipeline that computes the level
// in tenths of dB (saturated at 9999), the 0..16 bar count and the decimal digits, and
// the front takes a new sample every cycle while the queue has room. The back sequencer
// sends one result beat per cycle while result_stall is low: five to seven beats per
// sample when the link is connected and transmit is enabled (newline, digits, dot,
// tenths, tab), otherwise one beat with byte_valid low. Sustained rate is therefore
// set by the back sequencer; a sample's first beat passes the seven front stages, the
// queue and the back output registers before it is valid. The queue holds QUEUE_DEPTH
// samples between front and back. Latch hold reuses the last level computed with latch
// clear (zero after reset).
module sound_level_scale_format #(
    parameter int QUEUE_DEPTH = slsf_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [9:0]  adc_sample,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [13:0] level_tenths,
    output logic [4:0]  bar_blocks,
    output logic [7:0]  serial_byte,
    output logic        byte_valid,
    output logic        held,
    output logic        last
);

    logic [9:0] max_value_reg;
    logic       latch_hold_reg;
    logic       link_connected_reg;
    logic       transmit_enable_reg;

    slsf_pkg::cfg_t   cfg;
    slsf_pkg::entry_t push_data, head;
    logic             push, pop, full, empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg       <= slsf_pkg::MAX_VALUE_RESET;
            latch_hold_reg      <= 1'b0;
            link_connected_reg  <= 1'b0;
            transmit_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slsf_pkg::REG_MAX_VALUE:       max_value_reg       <= cfg_data;
                slsf_pkg::REG_LATCH_HOLD:      latch_hold_reg      <= cfg_data[0];
                slsf_pkg::REG_LINK_CONNECTED:  link_connected_reg  <= cfg_data[0];
                slsf_pkg::REG_TRANSMIT_ENABLE: transmit_enable_reg <= cfg_data[0];
                default:                       max_value_reg       <= max_value_reg;
            endcase
        end
    end

    assign cfg.max_value = max_value_reg;
    assign cfg.latch     = latch_hold_reg;
    assign cfg.frame_en  = link_connected_reg && transmit_enable_reg;

    slsf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .cfg          (cfg),
        .full         (full),
        .push         (push),
        .push_data    (push_data)
    );

    slsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    slsf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .level_tenths (level_tenths),
        .bar_blocks   (bar_blocks),
        .serial_byte  (serial_byte),
        .byte_valid   (byte_valid),
        .held         (held),
        .last         (last)
    );

endmodule

// ===== sv/slsf_front.sv =====
// Front pipeline: accepts samples, computes level, bar count and decimal digits.
// Depends on slsf_pkg; feeds slsf_queue.
module slsf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [9:0]          adc_sample,
    input  slsf_pkg::cfg_t      cfg,
    input  logic                full,
    output logic                push,
    output slsf_pkg::entry_t    push_data
);

    logic [7:1] v_reg;
    logic       adv;

    logic [20:0] s1_prod_reg;
    logic [4:0]  s1_bars_reg;
    logic        s1_latch_reg, s1_frame_reg;
    logic [23:0] s2_p_reg;
    logic [4:0]  s2_bars_reg;
    logic        s2_latch_reg, s2_frame_reg;
    logic [23:0] s3_p_reg;
    logic [14:0] s3_q0_reg;
    logic        s3_sat_reg;
    logic [4:0]  s3_bars_reg;
    logic        s3_latch_reg, s3_frame_reg;

    slsf_pkg::entry_t s4_reg, s5_reg, s6_reg, s7_reg;
    slsf_pkg::entry_t s4_next, s5_next, s6_next, s7_next;
    logic [9:0]  s5_rem_reg;
    logic [6:0]  s6_rem_reg;

    logic [13:0] held_level_reg, held_level_next;
    logic [4:0]  held_bars_reg, held_bars_next;

    logic [10:0] doubled;
    logic [46:0] recip_prod;
    logic [23:0] resid;
    logic [14:0] quot;
    logic [13:0] level_new;
    logic [3:0]  th, hu, te;
    logic [13:0] rem1_full, rem2_full;
    logic [6:0]  un_full;

    assign adv          = !v_reg[7] || !full;
    assign sample_stall = !adv;
    assign push         = v_reg[7] && !full;
    assign push_data    = s7_reg;

    assign doubled    = {adc_sample, 1'b0};
    assign recip_prod = 47'(s2_p_reg) * 47'(slsf_pkg::RECIP_767);

    // quotient estimate is low by at most one; fix with a single compare
    assign resid     = s3_p_reg - 24'(s3_q0_reg) * slsf_pkg::DIVISOR;
    assign quot      = s3_q0_reg + 15'(resid >= slsf_pkg::DIVISOR);
    assign level_new = s3_sat_reg ? slsf_pkg::LEVEL_MAX : quot[13:0];

    always_comb
    begin
        held_level_next = held_level_reg;
        held_bars_next  = held_bars_reg;
        if (adv && v_reg[3] && !s3_latch_reg)
        begin
            held_level_next = level_new;
            held_bars_next  = s3_bars_reg;
        end
        s4_next          = '0;
        s4_next.level    = s3_latch_reg ? held_level_reg : level_new;
        s4_next.bars     = s3_latch_reg ? held_bars_reg : s3_bars_reg;
        s4_next.held     = s3_latch_reg;
        s4_next.frame_en = s3_frame_reg;
    end

    assign th        = slsf_pkg::digit_of(s4_reg.level, 14'd1000);
    assign rem1_full = s4_reg.level - 14'(th) * 14'd1000;
    assign hu        = slsf_pkg::digit_of(14'(s5_rem_reg), 14'd100);
    assign rem2_full = 14'(s5_rem_reg) - 14'(hu) * 14'd100;
    assign te        = slsf_pkg::digit_of(14'(s6_rem_reg), 14'd10);
    assign un_full   = s6_rem_reg - 7'(te) * 7'd10;

    always_comb
    begin
        s5_next    = s4_reg;
        s5_next.th = th;
        s6_next    = s5_reg;
        s6_next.hu = hu;
        s7_next    = s6_reg;
        s7_next.te = te;
        s7_next.un = un_full[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            held_level_reg <= '0;
            held_bars_reg  <= '0;
        end
        else
        begin
            held_level_reg <= held_level_next;
            held_bars_reg  <= held_bars_next;
            if (adv)
                v_reg <= {v_reg[6:1], sample_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg  <= 21'(doubled) * 21'(cfg.max_value);
            s1_bars_reg  <= slsf_pkg::bar_count(doubled);
            s1_latch_reg <= cfg.latch;
            s1_frame_reg <= cfg.frame_en;

            s2_p_reg     <= 24'(s1_prod_reg) * 24'd5;
            s2_bars_reg  <= s1_bars_reg;
            s2_latch_reg <= s1_latch_reg;
            s2_frame_reg <= s1_frame_reg;

            s3_p_reg     <= s2_p_reg;
            s3_q0_reg    <= recip_prod[46:32];
            s3_sat_reg   <= s2_p_reg >= slsf_pkg::SAT_THRESH;
            s3_bars_reg  <= s2_bars_reg;
            s3_latch_reg <= s2_latch_reg;
            s3_frame_reg <= s2_frame_reg;

            s4_reg <= s4_next;

            s5_reg     <= s5_next;
            s5_rem_reg <= rem1_full[9:0];

            s6_reg     <= s6_next;
            s6_rem_reg <= rem2_full[6:0];

            s7_reg <= s7_next;
        end
    end

    // a latched beat in stage 4 must carry the level still held
    a_latched_level: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[4] && s4_reg.held) |-> (s4_reg.level == held_level_reg))
        else $error("latched level differs from held level");

endmodule

// ===== sv/slsf_queue.sv =====
// Short queue between the front pipeline and the frame sequencer.
// Depends on slsf_pkg for the entry type.
module slsf_queue #(
    parameter int DEPTH = slsf_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  slsf_pkg::entry_t  push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output slsf_pkg::entry_t  head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    slsf_pkg::entry_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = count_reg == CW'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> !(count_reg > CW'(DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

// ===== sv/slsf_back.sv =====
// Frame sequencer: turns queued levels into beats of at most one frame byte each.
// Depends on slsf_pkg; reads the head of slsf_queue.
module slsf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  slsf_pkg::entry_t  head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [13:0]       level_tenths,
    output logic [4:0]        bar_blocks,
    output logic [7:0]        serial_byte,
    output logic              byte_valid,
    output logic              held,
    output logic              last
);

    slsf_pkg::frame_state_t state_reg, state_next;
    logic        result_valid_reg;
    logic [13:0] level_reg;
    logic [4:0]  bars_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        byte_valid_reg, byte_valid_next;
    logic        held_reg;
    logic        last_reg, last_next;
    logic        load;

    assign load = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = 8'd0;
        byte_valid_next = 1'b1;
        last_next       = 1'b0;
        pop             = 1'b0;
        if (load && !empty)
        begin
            if (!head.frame_en)
            begin
                byte_valid_next = 1'b0;
                last_next       = 1'b1;
                pop             = 1'b1;
            end
            else
            begin
                unique case (state_reg)
                    slsf_pkg::ST_NL:
                    begin
                        byte_next = slsf_pkg::CHAR_NL;
                        if (head.level > 14'd999)
                            state_next = slsf_pkg::ST_TH;
                        else if (head.level > 14'd99)
                            state_next = slsf_pkg::ST_HU;
                        else
                            state_next = slsf_pkg::ST_TE;
                    end
                    slsf_pkg::ST_TH:
                    begin
                        byte_next  = slsf_pkg::CHAR_ZERO + 8'(head.th);
                        state_next = slsf_pkg::ST_HU;
                    end
                    slsf_pkg::ST_HU:
                    begin
                        byte_next  = slsf_pkg::CHAR_ZERO + 8'(head.hu);
                        state_next = slsf_pkg::ST_TE;
                    end
                    slsf_pkg::ST_TE:
                    begin
                        byte_next  = slsf_pkg::CHAR_ZERO + 8'(head.te);
                        state_next = slsf_pkg::ST_DOT;
                    end
                    slsf_pkg::ST_DOT:
                    begin
                        byte_next  = slsf_pkg::CHAR_DOT;
                        state_next = slsf_pkg::ST_UN;
                    end
                    slsf_pkg::ST_UN:
                    begin
                        byte_next  = slsf_pkg::CHAR_ZERO + 8'(head.un);
                        state_next = slsf_pkg::ST_TAB;
                    end
                    slsf_pkg::ST_TAB:
                    begin
                        byte_next  = slsf_pkg::CHAR_TAB;
                        last_next  = 1'b1;
                        pop        = 1'b1;
                        state_next = slsf_pkg::ST_NL;
                    end
                    default:
                    begin
                        state_next = slsf_pkg::ST_NL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= slsf_pkg::ST_NL;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                result_valid_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            level_reg      <= head.level;
            bars_reg       <= head.bars;
            byte_reg       <= byte_next;
            byte_valid_reg <= byte_valid_next;
            held_reg       <= head.held;
            last_reg       <= last_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign level_tenths = level_reg;
    assign bar_blocks   = bars_reg;
    assign serial_byte  = byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign held         = held_reg;
    assign last         = last_reg;

    a_frame_ends_tab: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && byte_valid_reg && last_reg) |-> (byte_reg == slsf_pkg::CHAR_TAB))
        else $error("frame does not end with a tab");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !byte_valid_reg) |-> last_reg)
        else $error("beat without frame byte not marked last");

endmodule
